>>> src/aes128_block_encrypt_macros.svh
// Assertion macros shared by the AES-128 block encryption RTL.
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AES128_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AES128_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/aes128_pkg.sv
// Package for AES-128 block encryption: types, constants, S-box and GF helpers.
package aes128_pkg;

  localparam int unsigned BlockBits = 128;
  localparam int unsigned HalfBits  = 64;
  localparam int unsigned CfgIdxBits = 8;

  localparam logic [CfgIdxBits-1:0] REG_KEY_HI = 8'd0;
  localparam logic [CfgIdxBits-1:0] REG_KEY_LO = 8'd1;

  localparam logic [HalfBits-1:0] KEY_HI_RESET = 64'h0001020304050607;
  localparam logic [HalfBits-1:0] KEY_LO_RESET = 64'h08090a0b0c0d0e0f;

  localparam logic [7:0] GF_POLY    = 8'h1b;
  localparam logic [7:0] RCON_FIRST = 8'h01;

  localparam logic [3:0] ROUND_FIRST = 4'd1;
  localparam logic [3:0] ROUND_LAST  = 4'd10;

  typedef logic [BlockBits-1:0] aes128_block_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } aes128_state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input aes128_block_t blk, input logic [3:0] idx);
    return blk[(BlockBits - 1) - 8 * idx -: 8];
  endfunction

endpackage

>>> src/aes128_key_step.sv
// On-the-fly AES-128 key expansion: one round key to the next.
module aes128_key_step (
  input  aes128_pkg::aes128_block_t rk_i,
  input  logic [7:0]                rcon_i,
  output aes128_pkg::aes128_block_t rk_o
);
  import aes128_pkg::*;

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] t;
  logic [31:0] n0, n1, n2, n3;

  assign {w0, w1, w2, w3} = rk_i;

  // RotWord, SubWord, then fold in the round constant.
  assign t = {sbox(w3[23:16]) ^ rcon_i, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};

  assign n0 = w0 ^ t;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;

  assign rk_o = {n0, n1, n2, n3};

endmodule

>>> src/aes128_round.sv
// One AES cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes128_round (
  input  aes128_pkg::aes128_block_t state_i,
  input  aes128_pkg::aes128_block_t rk_i,
  input  logic                      mix_i,
  output aes128_pkg::aes128_block_t state_o
);
  import aes128_pkg::*;

  aes128_block_t shifted;
  aes128_block_t mixed;

  // Substitute and shift: row r of column c takes column (c + r) mod 4.
  always_comb begin
    shifted = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[(BlockBits - 1) - 8 * (r + 4 * c) -: 8] =
          sbox(get_byte(state_i, 4'(r + 4 * ((c + r) % 4))));
      end
    end
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, all;
    mixed = shifted;
    for (int c = 0; c < 4; c++) begin
      a0  = get_byte(shifted, 4'(4 * c));
      a1  = get_byte(shifted, 4'(4 * c + 1));
      a2  = get_byte(shifted, 4'(4 * c + 2));
      a3  = get_byte(shifted, 4'(4 * c + 3));
      all = a0 ^ a1 ^ a2 ^ a3;
      mixed[(BlockBits - 1) - 32 * c -: 32] = {
        a0 ^ all ^ gf_double(a0 ^ a1),
        a1 ^ all ^ gf_double(a1 ^ a2),
        a2 ^ all ^ gf_double(a2 ^ a3),
        a3 ^ all ^ gf_double(a3 ^ a0)
      };
    end
  end

  assign state_o = (mix_i ? mixed : shifted) ^ rk_i;

endmodule

>>> src/aes128_block_encrypt.sv
// Top level of the AES-128 block encryption core with its round sequencer.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one 128-bit plaintext
//    block per transaction, split into plaintext_hi_i and plaintext_lo_i.
//  - Output channel (out_valid_o / out_ready_i) returns one ciphertext block
//    per input transaction, in order.
//  - Configuration channel (cfg_valid_i / cfg_ready_o) writes the cipher key:
//    index 0 is key_hi, index 1 is key_lo; other indexes are dropped. It is
//    always ready. Write it only while the core is idle.
//  - Timing: the accept cycle loads state ^ key, then one round per cycle on
//    the shared round unit, so the ciphertext lands in the output register
//    after the last round. A new block is taken in the next cycle; no block
//    is taken while the previous one is still in the rounds. The round unit
//    and the key step unit work in the same cycle for each round.
//  - Reset clears the sequencer and the output valid, and loads the key with
//    00 01 .. 0f.
//  - When the receiver stalls, the result holds in the output register; a
//    block finishing meanwhile parks in the state register and the input
//    stays not ready until the output register frees.
`include "aes128_block_encrypt_macros.svh"

module aes128_block_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] plaintext_hi_i,
  input  logic [63:0] plaintext_lo_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] ciphertext_hi_o,
  output logic [63:0] ciphertext_lo_o
);
  import aes128_pkg::*;

  aes128_state_e state_q, state_d;

  logic [HalfBits-1:0] key_hi_q, key_lo_q;
  aes128_block_t       state_blk_q;
  aes128_block_t       rk_q;
  logic [7:0]          rcon_q;
  logic [3:0]          round_q;
  logic                out_valid_q;
  aes128_block_t       out_blk_q;

  aes128_block_t rk_next;
  aes128_block_t round_out;
  aes128_block_t key_blk;
  logic          out_free;
  logic          load_in;
  logic          step;
  logic          out_load;
  logic          out_sel_round;

  assign key_blk = {key_hi_q, key_lo_q};

  // Key schedule advances alongside the round, so the round sees its own key.
  aes128_key_step u_key_step (
    .rk_i   (rk_q),
    .rcon_i (rcon_q),
    .rk_o   (rk_next)
  );

  aes128_round u_round (
    .state_i (state_blk_q),
    .rk_i    (rk_next),
    .mix_i   (round_q != ROUND_LAST),
    .state_o (round_out)
  );

  // Configuration: always accept, drop writes to unknown indexes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= KEY_HI_RESET;
      key_lo_q <= KEY_LO_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KEY_HI: key_hi_q <= cfg_data_i;
        REG_KEY_LO: key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    load_in       = 1'b0;
    step          = 1'b0;
    out_load      = 1'b0;
    out_sel_round = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load_in = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        step = 1'b1;
        if (round_q == ROUND_LAST) begin
          if (out_free) begin
            // Hand the final round straight to the output register.
            out_load      = 1'b1;
            out_sel_round = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Round counter is control state; the block and key registers are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= ROUND_FIRST;
    end else if (load_in) begin
      round_q <= ROUND_FIRST;
    end else if (step && round_q != ROUND_LAST) begin
      round_q <= round_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      state_blk_q <= {plaintext_hi_i, plaintext_lo_i} ^ key_blk;
      rk_q        <= key_blk;
      rcon_q      <= RCON_FIRST;
    end else if (step) begin
      state_blk_q <= round_out;
      rk_q        <= rk_next;
      rcon_q      <= gf_double(rcon_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_blk_q <= out_sel_round ? round_out : state_blk_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ciphertext_hi_o = out_blk_q[BlockBits-1:HalfBits];
  assign ciphertext_lo_o = out_blk_q[HalfBits-1:0];

  `AES128_ASSERT_NXT(a_accept_starts_run, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_RUN && round_q == ROUND_FIRST, "accepted block did not start at the first round")
  `AES128_ASSERT_IMP(a_wait_means_full, clk_i, rst_ni, state_q == ST_WAIT, out_valid_q, "parked result while output register is empty")
  `AES128_ASSERT_NXT(a_last_round_leaves, clk_i, rst_ni, state_q == ST_RUN && round_q == ROUND_LAST, state_q != ST_RUN, "sequencer ran past the last round")

endmodule

>>> bench/aes128_block_encrypt_tb.sv
// Self-checking testbench for the AES-128 block encryption core.
module aes128_block_encrypt_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aes128_pkg::*;

  // Cipher constants used by the predictor.
  localparam logic [7:0] AFFINE_CONST = 8'h63;
  localparam logic [7:0] REDUCE_POLY  = 8'h1b;
  localparam int         NUM_ROUNDS   = 10;

  // Indexes outside the key registers; writes to them must be dropped.
  localparam logic [7:0] REG_IDX_FIRST_UNUSED = 8'd2;
  localparam logic [7:0] REG_IDX_TOP          = 8'hff;

  localparam int RESET_CYCLES  = 8;
  localparam int DRAIN_CYCLES  = 24;
  localparam int HOLD_CYCLES   = 250;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 490;
  localparam int REKEY_EVERY   = 150;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] plaintext_hi_i;
  logic [63:0] plaintext_lo_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] ciphertext_hi_o;
  logic [63:0] ciphertext_lo_o;

  aes128_block_encrypt dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .plaintext_hi_i  (plaintext_hi_i),
    .plaintext_lo_i  (plaintext_lo_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ciphertext_hi_o (ciphertext_hi_o),
    .ciphertext_lo_o (ciphertext_lo_o)
  );

  // Mirror of the key registers, updated on every accepted write to a key register.
  logic [63:0] key_hi_mirror;
  logic [63:0] key_lo_mirror;

  // Ciphertexts owed by the core, oldest first.
  cipher_t ciphertext_q [$];

  // S-box, derived from the field inverse and the affine map at startup.
  logic [7:0] sub_lut [256];

  int fail_count;
  int cycle_count;
  int sender_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = 8'h00;
    sh  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= sh;
      sh = xtime(sh);
    end
    return acc;
  endfunction

  // Fill the S-box: inverse is x^254 (zero maps to zero), then the affine step.
  function automatic void build_sub_lut();
    logic [7:0] inv;
    logic [7:0] sq;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      sq  = x[7:0];
      for (int k = 1; k < 8; k++) begin
        sq  = gf_mul(sq, sq);
        inv = gf_mul(inv, sq);
      end
      sub_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                   {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_CONST;
    end
  endfunction

  // Full AES-128 encryption; byte i sits at bits [127-8i -: 8], state byte r+4c.
  function automatic cipher_t encrypt_block(input logic [63:0] k_hi, input logic [63:0] k_lo,
                                            input logic [63:0] p_hi, input logic [63:0] p_lo);
    logic [7:0]   st [16];
    logic [7:0]   rk [16];
    logic [7:0]   nx [16];
    logic [7:0]   tw [4];
    logic [127:0] kb;
    logic [127:0] pb;
    logic [127:0] cb;
    logic [7:0]   rcon;
    logic [7:0]   a0, a1, a2, a3, mix_all;
    kb = {k_hi, k_lo};
    pb = {p_hi, p_lo};
    for (int i = 0; i < 16; i++) begin
      rk[i] = kb[127 - 8 * i -: 8];
      st[i] = pb[127 - 8 * i -: 8] ^ rk[i];
    end
    rcon = 8'h01;
    for (int rnd = 1; rnd <= NUM_ROUNDS; rnd++) begin
      // Step the round key.
      tw[0] = sub_lut[rk[13]] ^ rcon;
      tw[1] = sub_lut[rk[14]];
      tw[2] = sub_lut[rk[15]];
      tw[3] = sub_lut[rk[12]];
      for (int i = 0; i < 4; i++) rk[i] ^= tw[i];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
      rcon = xtime(rcon);
      // SubBytes and ShiftRows together.
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          nx[r + 4 * c] = sub_lut[st[r + 4 * ((c + r) % 4)]];
      if (rnd < NUM_ROUNDS) begin
        for (int c = 0; c < 4; c++) begin
          a0 = nx[4 * c];
          a1 = nx[4 * c + 1];
          a2 = nx[4 * c + 2];
          a3 = nx[4 * c + 3];
          mix_all = a0 ^ a1 ^ a2 ^ a3;
          nx[4 * c]     = a0 ^ mix_all ^ xtime(a0 ^ a1);
          nx[4 * c + 1] = a1 ^ mix_all ^ xtime(a1 ^ a2);
          nx[4 * c + 2] = a2 ^ mix_all ^ xtime(a2 ^ a3);
          nx[4 * c + 3] = a3 ^ mix_all ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = nx[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) cb[127 - 8 * i -: 8] = st[i];
    return cb;
  endfunction

  // Append one prediction at the tail of the owed list.
  function automatic void owe_ciphertext(input cipher_t c);
    ciphertext_q.insert(ciphertext_q.size(), c);
  endfunction

  // Guard the predictor itself against a published test vector.
  task automatic check_known_answer(input logic [127:0] key, input logic [127:0] pt,
                                    input logic [127:0] ct);
    cipher_t got;
    got = encrypt_block(key[127:64], key[63:0], pt[127:64], pt[63:0]);
    if (got !== ct) begin
      $display("%0t predictor known-answer mismatch expected %h actual %h", $time, ct, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit and receiver
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // End the run at the cycle limit, as a guard against a core that stops making progress.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t cycle limit reached with %0d ciphertexts pending", $time,
               ciphertext_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Drive out_ready_i at random; a hold request blocks it for a long stretch,
  // counted here so the sender keeps offering blocks meanwhile.
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare every accepted ciphertext with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    cipher_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ciphertext_q.size() == 0) begin
        $display("%0t unexpected ciphertext, expected none actual %h %h", $time,
                 ciphertext_hi_o, ciphertext_lo_o);
        fail_count++;
      end else begin
        want = ciphertext_q.pop_front();
        if (ciphertext_hi_o !== want.hi) begin
          $display("%0t ciphertext_hi mismatch expected %h actual %h", $time,
                   want.hi, ciphertext_hi_o);
          fail_count++;
        end
        if (ciphertext_lo_o !== want.lo) begin
          $display("%0t ciphertext_lo mismatch expected %h actual %h", $time,
                   want.lo, ciphertext_lo_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one plaintext block; leave valid high after the transaction so the
  // next block can follow back to back.
  task automatic send_plaintext(input logic [63:0] p_hi, input logic [63:0] p_lo);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    plaintext_hi_i = p_hi;
    plaintext_lo_i = p_lo;
    do @(posedge clk_i); while (!in_ready_o);
    owe_ciphertext(encrypt_block(key_hi_mirror, key_lo_mirror, p_hi, p_lo));
  endtask

  // Drop valid, wait for every owed ciphertext, then let the core settle.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (ciphertext_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; call only with the core idle.
  task automatic write_key_reg(input logic [7:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_KEY_HI: key_hi_mirror = data;
      REG_KEY_LO: key_lo_mirror = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random half block, biased a little toward the all-zero and all-one corners.
  function automatic logic [63:0] pick_half();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Encrypt corner blocks under the key loaded by reset.
  task automatic test_reset_key();
    check_known_answer({KEY_HI_RESET, KEY_LO_RESET}, 128'h00112233445566778899aabbccddeeff,
                       128'h69c4e0d86a7b0430d8cdb78070b4c55a);
    send_plaintext(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_plaintext('0, '0);
    send_plaintext('1, '1);
    send_plaintext(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_plaintext(64'h8000000000000000, 64'h0000000000000001);
    drain_results();
  endtask

  // Walk the key through known and extreme values, both registers but in the last step.
  task automatic test_key_extremes();
    check_known_answer(128'h2b7e151628aed2a6abf7158809cf4f3c,
                       128'h3243f6a8885a308d313198a2e0370734,
                       128'h3925841d02dc09fbdc118597196a0b32);
    write_key_reg(REG_KEY_HI, 64'h2b7e151628aed2a6);
    write_key_reg(REG_KEY_LO, 64'habf7158809cf4f3c);
    send_plaintext(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    drain_results();
    write_key_reg(REG_KEY_HI, '0);
    write_key_reg(REG_KEY_LO, '0);
    send_plaintext('0, '0);
    send_plaintext('1, '1);
    drain_results();
    write_key_reg(REG_KEY_HI, '1);
    write_key_reg(REG_KEY_LO, '1);
    send_plaintext('0, '0);
    send_plaintext('1, '1);
    drain_results();
    // Change only the low half; the high half must keep its value.
    write_key_reg(REG_KEY_LO, 64'h0123456789abcdef);
    send_plaintext(64'hfedcba9876543210, '0);
    drain_results();
  endtask

  // Writes outside the two key registers must leave the key alone.
  task automatic test_ignored_index();
    write_key_reg(REG_IDX_FIRST_UNUSED, '0);
    write_key_reg(REG_IDX_TOP, {$urandom, $urandom});
    send_plaintext(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain_results();
  endtask

  // A new key applies from the very next block.
  task automatic test_key_change();
    write_key_reg(REG_KEY_HI, KEY_HI_RESET);
    write_key_reg(REG_KEY_LO, KEY_LO_RESET);
    send_plaintext(64'hdeadbeefcafef00d, 64'h0f1e2d3c4b5a6978);
    drain_results();
    write_key_reg(REG_KEY_HI, 64'hffffffff00000000);
    send_plaintext(64'hdeadbeefcafef00d, 64'h0f1e2d3c4b5a6978);
    drain_results();
    write_key_reg(REG_KEY_LO, 64'h00000000ffffffff);
    send_plaintext(64'hdeadbeefcafef00d, 64'h0f1e2d3c4b5a6978);
    drain_results();
  endtask

  // Stall the receiver for a long stretch so the core fills and blocks its
  // input, then pause the sender until every ciphertext has come back.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    @(posedge clk_i);
    hold_req = 1'b1;
    for (int n = 0; n < 12; n++) send_plaintext(pick_half(), pick_half());
    drain_results();
    for (int n = 0; n < 6; n++) send_plaintext(pick_half(), pick_half());
    drain_results();
  endtask

  // Random blocks under one idling pattern; rekey at random every so often.
  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % REKEY_EVERY == 0) begin
        drain_results();
        write_key_reg(REG_KEY_HI, pick_half());
        write_key_reg(REG_KEY_LO, pick_half());
        // Now and then throw in a write to an arbitrary index.
        if ($urandom_range(3) == 0) write_key_reg(8'($urandom_range(255)), pick_half());
      end
      send_plaintext(pick_half(), pick_half());
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0);
    run_random_phase(66, 0);
    run_random_phase(0, 66);
    run_random_phase(38, 38);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    fail_count      = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    key_hi_mirror   = KEY_HI_RESET;
    key_lo_mirror   = KEY_LO_RESET;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    plaintext_hi_i  = '0;
    plaintext_lo_i  = '0;
    build_sub_lut();

    // Hold reset, then release it away from the rising edge.
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_key();
    test_key_extremes();
    test_ignored_index();
    test_key_change();
    test_backpressure();
    test_random_traffic();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
